// ===== sv/plp_pkg.sv =====
// package for the positional list: request/response structs, codes and the
// per-cell shift command; depends on nothing
`timescale 1ns / 1ps
package plp_pkg;

	// fixed field widths of the request and response
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int CAP_W    = 7;

	// defaults handed to the top level
	localparam int DEPTH_DEFAULT      = 64;
	localparam int ELEM_WIDTH_DEFAULT = 32;

	// widest cell index the command carries (depth up to 1024)
	localparam int IDX_MAX_W = 10;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// request operations
	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd2;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value_out;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
	} rsp_t;

	// what every cell does in the current cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [IDX_MAX_W-1:0] idx;
	} cell_cmd_t;

endpackage

// ===== sv/plp_cell.sv =====
// one storage cell of the list row: holds one entry and shifts with its
// neighbors; depends on plp_pkg
`timescale 1ns / 1ps
module plp_cell
	import plp_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
	parameter int CELL_IDX   = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [ELEM_WIDTH-1:0] wdata,
	input  logic [ELEM_WIDTH-1:0] left_data,
	input  logic [ELEM_WIDTH-1:0] right_data,
	output logic [ELEM_WIDTH-1:0] data,
	output logic [ELEM_WIDTH-1:0] sel_data
);

	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);

	logic [ELEM_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  below;

	// position of the target relative to this cell
	assign hit   = (cmd.idx == MY_IDX);
	assign below = (cmd.idx < MY_IDX);

	// insert pulls from the left, delete pulls from the right
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (hit) begin
					data_q <= wdata;
				end else if (below) begin
					data_q <= left_data;
				end
			end
			CELL_DEL: begin
				if (hit || below) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data     = data_q;
	assign sel_data = hit ? data_q : '0;

endmodule

// ===== sv/plp_ctrl.sv =====
// list control: fill count, capacity register, request checks, cell command
// and the registered response; depends on plp_pkg
`timescale 1ns / 1ps
module plp_ctrl
	import plp_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  req_t                req,
	input  logic                cfg_we,
	input  logic [CAP_W-1:0]    cfg_wdata,
	input  logic [VALUE_W-1:0]  rd_data,
	output cell_cmd_t           cmd,
	output logic                done,
	output rsp_t                rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [EW:0] DEPTH_E = (EW + 1)'(DEPTH);

	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_d;
	logic [CAP_W-1:0]    cap_q;
	logic                done_q;
	rsp_t                rsp_q;
	logic [STATUS_W-1:0] status_d;
	logic [VALUE_W-1:0]  rmv_d;
	logic [EW:0]         pos_e;
	logic [EW:0]         cnt_e;
	logic [EW:0]         cap_e;
	logic [EW:0]         eff_e;
	logic                pos_ok;

	// operands widened to one common width
	assign pos_e  = {{(EW + 1 - POS_W){1'b0}}, req.position};
	assign cnt_e  = {{(EW + 1 - CW){1'b0}}, cnt_q};
	assign cap_e  = {{(EW + 1 - CAP_W){1'b0}}, cap_q};
	assign eff_e  = (cap_e > DEPTH_E) ? DEPTH_E : cap_e;
	assign pos_ok = (req.position != '0) && (pos_e <= cnt_e + (EW + 1)'(1));

	// request decode and checks
	always_comb begin
		status_d = ST_OK;
		rmv_d    = '0;
		cnt_d    = cnt_q;
		cmd.op   = CELL_HOLD;
		cmd.idx  = IDX_MAX_W'(req.position - POS_W'(1));
		if (start) begin
			unique case (req.func)
				OP_INSERT: begin
					if (!pos_ok) begin
						status_d = ST_BADPOS;
					end else if (cnt_e >= eff_e) begin
						status_d = ST_FULL;
					end else begin
						cmd.op = CELL_INS;
						cnt_d  = cnt_q + CW'(1);
					end
				end
				OP_DELETE: begin
					if (!pos_ok) begin
						status_d = ST_BADPOS;
					end else if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else if (pos_e > cnt_e) begin
						status_d = ST_BADPOS;
					end else begin
						cmd.op = CELL_DEL;
						rmv_d  = rd_data;
						cnt_d  = cnt_q - CW'(1);
					end
				end
				OP_CLEAR: begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						cnt_d = '0;
					end
				end
				default: begin
					status_d = ST_OK;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cap_q  <= CAP_RESET;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= start;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (start) begin
			rsp_q.status    <= status_d;
			rsp_q.value_out <= rmv_d;
			rsp_q.count     <= COUNT_W'(cnt_d);
			rsp_q.is_empty  <= (cnt_d == '0);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== sv/positional_list_insert_delete.sv =====
// Positional list of words held in a row of shifting cells. A request is
// taken at every clock edge where start is high; busy stays low, so one
// request per cycle is sustained. The response appears on rsp with done high
// for exactly one cycle, the cycle after the request, and must be taken then.
// Insert and delete end then, since every cell moves its entry to a neighbor in
// parallel; the removed word is picked from the row before the shift. The user
// writes capacity on cfg_we/cfg_wdata only while idle, unchecked by the block.
// depends on plp_pkg, plp_ctrl, plp_cell
`timescale 1ns / 1ps
module positional_list_insert_delete
	import plp_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEFAULT,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             rsp
);

	cell_cmd_t             cmd;
	logic [ELEM_WIDTH-1:0] wdata;
	logic [ELEM_WIDTH-1:0] rd_elem;
	logic [VALUE_W-1:0]    rd_data;
	logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
	logic [ELEM_WIDTH-1:0] cell_sel [DEPTH];

	assign busy = 1'b0;

	// word width adaption between the ports and the cells
	generate
		if (ELEM_WIDTH >= VALUE_W) begin : g_wide
			assign wdata   = {{(ELEM_WIDTH - VALUE_W){1'b0}}, req.value_in};
			assign rd_data = rd_elem[VALUE_W-1:0];
		end else begin : g_narrow
			assign wdata   = req.value_in[ELEM_WIDTH-1:0];
			assign rd_data = {{(VALUE_W - ELEM_WIDTH){1'b0}}, rd_elem};
		end
	endgenerate

	// read of the addressed entry: only the hit cell drives non-zero
	always_comb begin
		rd_elem = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_elem = rd_elem | cell_sel[k];
		end
	end

	plp_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rd_data  (rd_data),
		.cmd      (cmd),
		.done     (done),
		.rsp      (rsp)
	);

	// row of cells, each wired to both neighbors
	generate
		for (genvar k = 0; k < DEPTH; k++) begin : g_cell
			logic [ELEM_WIDTH-1:0] left_w;
			logic [ELEM_WIDTH-1:0] right_w;

			if (k == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_data[k-1];
			end

			if (k == DEPTH - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = cell_data[k+1];
			end

			plp_cell #(
				.ELEM_WIDTH(ELEM_WIDTH),
				.CELL_IDX  (k)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.wdata     (wdata),
				.left_data (left_w),
				.right_data(right_w),
				.data      (cell_data[k]),
				.sel_data  (cell_sel[k])
			);
		end
	endgenerate

endmodule

// ===== verif/positional_list_insert_delete_test.sv =====
// self-checking test for positional_list_insert_delete: directed corner requests,
// then random insert/delete/clear traffic over several capacity settings
// depends on plp_pkg and the positional_list_insert_delete rtl
`timescale 1ns / 1ps
module positional_list_insert_delete_test
	import plp_pkg::*;
();

	localparam int PHASE_ITEMS    = 250;
	localparam int NUM_PHASES     = 7;
	localparam int WATCHDOG_LIMIT = 1000;
	// func code the block leaves unused
	localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

	// shadow of the list and the queue of responses still owed by the block
	class list_scoreboard;
		logic [VALUE_W-1:0] shadow_words[$];
		rsp_t               owed_rsps[$];
		int unsigned        capacity;
		int unsigned        errors;
		int unsigned        status_hits[4];
		int unsigned        longest;

		function new();
			capacity = CAP_RESET;
			errors = 0;
			longest = 0;
			foreach (status_hits[k]) status_hits[k] = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			capacity = v;
		endfunction

		function int unsigned length();
			return shadow_words.size();
		endfunction

		function int unsigned pending();
			return owed_rsps.size();
		endfunction

		// apply one accepted request to the shadow list and queue its response
		function void note_request(req_t r);
			rsp_t        e;
			int unsigned n;
			int unsigned lim;
			int unsigned p;
			n = shadow_words.size();
			lim = (capacity > DEPTH_DEFAULT) ? DEPTH_DEFAULT : capacity;
			p = r.position;
			e = '0;
			e.status = ST_OK;
			case (r.func)
				OP_INSERT: begin
					if (p < 1 || p > n + 1)
						e.status = ST_BADPOS;
					else if (n >= lim)
						e.status = ST_FULL;
					else
						shadow_words.insert(p - 1, r.value_in);
				end
				OP_DELETE: begin
					if (p < 1 || p > n + 1)
						e.status = ST_BADPOS;
					else if (n == 0)
						e.status = ST_EMPTY;
					else if (p > n)
						e.status = ST_BADPOS;
					else begin
						e.value_out = shadow_words[p - 1];
						shadow_words.delete(p - 1);
					end
				end
				OP_CLEAR: begin
					if (n == 0)
						e.status = ST_EMPTY;
					else
						shadow_words.delete();
				end
				default: ;
			endcase
			e.count = COUNT_W'(shadow_words.size());
			e.is_empty = (shadow_words.size() == 0);
			status_hits[e.status]++;
			if (shadow_words.size() > longest) longest = shadow_words.size();
			owed_rsps.push_back(e);
		endfunction

		// compare one response transfer against the oldest owed response
		function void check_response(rsp_t got);
			rsp_t e;
			if (owed_rsps.size() == 0) begin
				$display("%0t: response with none outstanding: %p", $time, got);
				errors++;
				return;
			end
			e = owed_rsps.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d, actual %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.value_out !== e.value_out) begin
				$display("%0t: value_out expected %h, actual %h", $time, e.value_out,
					got.value_out);
				errors++;
			end
			if (got.count !== e.count) begin
				$display("%0t: count expected %0d, actual %0d", $time, e.count, got.count);
				errors++;
			end
			if (got.is_empty !== e.is_empty) begin
				$display("%0t: is_empty expected %0d, actual %0d", $time, e.is_empty,
					got.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             done;
	rsp_t             rsp;

	list_scoreboard sb;
	int unsigned    stall_cycles = 0;
	int unsigned    requests_sent = 0;
	bit             filling = 1'b1;

	positional_list_insert_delete i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response monitor
	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_response(rsp);
	end

	// count cycles where no transfer happens on either side
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 || cfg_we === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// one request transfer, held until the block takes it
	task automatic send_request(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		sb.note_request(r);
		requests_sent++;
	endtask

	task automatic send_fields(input logic [FUNC_W-1:0] f, input int unsigned p,
		input logic [VALUE_W-1:0] v);
		req_t r;
		r.func = f;
		r.position = POS_W'(p);
		r.value_in = v;
		send_request(r);
	endtask

	// hold off until every owed response has come back
	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_capacity(v);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed requests against the current length, some noise
	function automatic req_t random_request(bit grow);
		req_t        r;
		int unsigned n;
		int unsigned roll;
		n = sb.length();
		roll = $urandom_range(0, 99);
		r.value_in = $urandom();
		r.position = POS_W'($urandom_range(0, 127));
		r.func = FUNC_W'($urandom_range(0, 3));
		if (roll < 3) begin
			// noise: any func, any position
		end else if (roll < 4) begin
			r.func = OP_CLEAR;
		end else if (roll < 5) begin
			r.func = OP_UNUSED;
		end else if (roll < (grow ? 72 : 30)) begin
			r.func = OP_INSERT;
			r.position = POS_W'($urandom_range(1, n + 1));
		end else begin
			r.func = OP_DELETE;
			r.position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
		end
		return r;
	endfunction

	initial begin
		logic [CAP_W-1:0] cap_plan[NUM_PHASES];
		int unsigned      idle_pct;
		sb = new();
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_fields(OP_DELETE, 1, 32'h0);
		send_fields(OP_CLEAR, 0, 32'h0);
		send_fields(OP_DELETE, 0, 32'h0);
		send_fields(OP_INSERT, 0, 32'h1234_5678);
		send_fields(OP_INSERT, 2, 32'h1234_5678);
		// insert at front, end and middle, word extremes
		send_fields(OP_INSERT, 1, 32'h0000_0000);
		send_fields(OP_INSERT, 1, 32'hffff_ffff);
		send_fields(OP_INSERT, 3, 32'ha5a5_a5a5);
		send_fields(OP_INSERT, 2, 32'h5a5a_5a5a);
		// delete one past the end and far out of range
		send_fields(OP_DELETE, 5, 32'h0);
		send_fields(OP_DELETE, 127, 32'hffff_ffff);
		send_fields(OP_UNUSED, 64, 32'hdead_beef);
		// delete from middle, end, front, then clear what is left
		send_fields(OP_DELETE, 2, 32'h0);
		send_fields(OP_DELETE, 3, 32'h0);
		send_fields(OP_DELETE, 1, 32'h0);
		send_fields(OP_CLEAR, 65, 32'h0);
		// small capacity: full, and bad position ahead of full
		write_capacity(7'd2);
		send_fields(OP_INSERT, 1, 32'h0000_0001);
		send_fields(OP_INSERT, 2, 32'h8000_0000);
		send_fields(OP_INSERT, 1, 32'h7fff_ffff);
		send_fields(OP_INSERT, 4, 32'h7fff_ffff);
		// capacity below the current length
		write_capacity(7'd1);
		send_fields(OP_INSERT, 3, 32'hcafe_f00d);
		send_fields(OP_DELETE, 2, 32'h0);
		send_fields(OP_INSERT, 1, 32'hcafe_f00d);

		// random phases, each with its own capacity and sender idling
		cap_plan = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd2, 7'd65, 7'd0};
		cap_plan[NUM_PHASES - 1] = CAP_W'($urandom_range(3, 63));
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_capacity(cap_plan[ph]);
			idle_pct = (ph < 3) ? 10 : (ph < 5) ? 52 : 0;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 59) == 0) filling = !filling;
				send_request(random_request(filling));
				if ($urandom_range(1, 100) <= idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end else if ($urandom_range(0, 199) == 0) begin
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (5) @(posedge clk);
		$display("ran %0d requests over %0d capacity settings, longest list %0d",
			requests_sent, NUM_PHASES + 2, sb.longest);
		$display("statuses seen: ok %0d, bad position %0d, full %0d, empty %0d",
			sb.status_hits[ST_OK], sb.status_hits[ST_BADPOS], sb.status_hits[ST_FULL],
			sb.status_hits[ST_EMPTY]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
